>>> sv/biq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_pkg
// Shared types and constants for the biquad IIR filter core: coefficient
// register indexes, multiplier operand selection and controller commands.
// ----------------------------------------------------------------------------
package biq_pkg;

  // Configuration register index
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] REG_B0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_B1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_B2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_A1 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_A2 = 3'd4;

  // Operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_A1W1,
    MUL_A2W2,
    MUL_B1W1,
    MUL_B2W2,
    MUL_B0W0
  } mul_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic     load;      // take a new request, preset accumulators
    mul_sel_e mul_sel;   // operands of the product registered this cycle
    logic     fb_sub;    // subtract registered product from feedback sum
    logic     ff_add;    // add registered product to feedforward sum
    logic     w0_latch;  // round and clip feedback sum into w0
    logic     commit;    // load result register and advance delay line
  } biq_cmd_t;

endpackage

>>> sv/biq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_ctrl
// Sequencer for the biquad core. Steps the shared multiplier through the five
// coefficient products and owns both channel handshakes.
// ----------------------------------------------------------------------------
module biq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output biq_pkg::biq_cmd_t cmd_o
);
  import biq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_A1,
    ST_MUL_A2,
    ST_MUL_B1,
    ST_MUL_B2,
    ST_MUL_B0,
    ST_ACC_LAST,
    ST_FINISH
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   accept;
  logic   commit;

  assign accept = in_valid_i & in_ready_q;
  assign commit = (state_q == ST_FINISH) & (~out_valid_q | out_ready_i);

  // Raise valid on a new result, drop it once the held result is taken
  assign out_valid_d = commit | (out_valid_q & ~out_ready_i);

  // Decode commands from the current state
  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_sel  = MUL_A1W1;
    cmd_o.load     = accept;
    cmd_o.commit   = commit;
    case (state_q)
      ST_MUL_A1: cmd_o.mul_sel = MUL_A1W1;
      ST_MUL_A2: begin
        cmd_o.mul_sel = MUL_A2W2;
        cmd_o.fb_sub  = 1'b1;
      end
      ST_MUL_B1: begin
        cmd_o.mul_sel = MUL_B1W1;
        cmd_o.fb_sub  = 1'b1;
      end
      ST_MUL_B2: begin
        cmd_o.mul_sel  = MUL_B2W2;
        cmd_o.w0_latch = 1'b1;
        cmd_o.ff_add   = 1'b1;
      end
      ST_MUL_B0: begin
        cmd_o.mul_sel = MUL_B0W0;
        cmd_o.ff_add  = 1'b1;
      end
      ST_ACC_LAST: cmd_o.ff_add = 1'b1;
      default: ;
    endcase
  end

  // Hold state and handshake flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q    <= ST_MUL_A1;
            in_ready_q <= 1'b0;
          end
        end
        ST_MUL_A1:   state_q <= ST_MUL_A2;
        ST_MUL_A2:   state_q <= ST_MUL_B1;
        ST_MUL_B1:   state_q <= ST_MUL_B2;
        ST_MUL_B2:   state_q <= ST_MUL_B0;
        ST_MUL_B0:   state_q <= ST_ACC_LAST;
        ST_ACC_LAST: state_q <= ST_FINISH;
        ST_FINISH: begin
          if (commit) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> sv/biq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_datapath
// Coefficient registers, delay line, one shared signed multiplier with a
// registered product, feedback and feedforward accumulators, rounding and
// saturation, and the result register.
// ----------------------------------------------------------------------------
module biq_datapath #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 24,
  parameter int unsigned STATE_WIDTH  = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [biq_pkg::CfgIdxW-1:0]         cfg_addr_i,
  input  logic [COEF_WIDTH-1:0]               cfg_wdata_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_in_i,
  input  logic                                clear_delay_i,
  input  biq_pkg::biq_cmd_t                   cmd_i,
  output logic signed [SAMPLE_WIDTH-1:0]      sample_out_o,
  output logic                                saturated_o
);
  import biq_pkg::*;

  localparam int unsigned Frac   = COEF_WIDTH - 4;
  localparam int unsigned ProdW  = COEF_WIDTH + STATE_WIDTH;
  localparam int unsigned XW     = SAMPLE_WIDTH + Frac;
  localparam int unsigned AccW   = ((ProdW > XW) ? ProdW : XW) + 2;
  localparam int unsigned RndW   = AccW - Frac;
  localparam logic [AccW-1:0]       Half   = AccW'(1) << (Frac - 1);
  localparam logic [COEF_WIDTH-1:0] UnityQ = COEF_WIDTH'(1) << Frac;

  logic signed [COEF_WIDTH-1:0]   b0_q, b1_q, b2_q, a1_q, a2_q;
  logic signed [STATE_WIDTH-1:0]  w1_q, w2_q, w0_q;
  logic signed [COEF_WIDTH-1:0]   mul_c;
  logic signed [STATE_WIDTH-1:0]  mul_w;
  logic signed [ProdW-1:0]        prod_q;
  logic signed [AccW-1:0]         acc_fb_q, acc_ff_q;
  logic signed [RndW-1:0]         rnd_fb, rnd_ff;
  logic signed [STATE_WIDTH-1:0]  w0_d;
  logic signed [SAMPLE_WIDTH-1:0] y_d;
  logic                           fb_clip, ff_clip;
  logic                           sat_w0_q;
  logic signed [SAMPLE_WIDTH-1:0] sample_out_q;
  logic                           saturated_q;

  // Write coefficient registers; drop writes beyond the list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_q <= UnityQ;
      b1_q <= '0;
      b2_q <= '0;
      a1_q <= '0;
      a2_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_B0:  b0_q <= cfg_wdata_i;
        REG_B1:  b1_q <= cfg_wdata_i;
        REG_B2:  b2_q <= cfg_wdata_i;
        REG_A1:  a1_q <= cfg_wdata_i;
        REG_A2:  a2_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Select multiplier operands
  always_comb begin
    case (cmd_i.mul_sel)
      MUL_A1W1: begin mul_c = a1_q; mul_w = w1_q; end
      MUL_A2W2: begin mul_c = a2_q; mul_w = w2_q; end
      MUL_B1W1: begin mul_c = b1_q; mul_w = w1_q; end
      MUL_B2W2: begin mul_c = b2_q; mul_w = w2_q; end
      MUL_B0W0: begin mul_c = b0_q; mul_w = w0_q; end
      default:  begin mul_c = a1_q; mul_w = w1_q; end
    endcase
  end

  // Round by dropping the fraction (half an LSB is preset), then clip
  assign rnd_fb = acc_fb_q[AccW-1:Frac];
  assign rnd_ff = acc_ff_q[AccW-1:Frac];

  always_comb begin
    fb_clip = ~((&rnd_fb[RndW-1:STATE_WIDTH-1]) | ~(|rnd_fb[RndW-1:STATE_WIDTH-1]));
    if (fb_clip) begin
      w0_d = rnd_fb[RndW-1] ? {1'b1, {(STATE_WIDTH-1){1'b0}}}
                            : {1'b0, {(STATE_WIDTH-1){1'b1}}};
    end else begin
      w0_d = rnd_fb[STATE_WIDTH-1:0];
    end
    ff_clip = ~((&rnd_ff[RndW-1:SAMPLE_WIDTH-1]) | ~(|rnd_ff[RndW-1:SAMPLE_WIDTH-1]));
    if (ff_clip) begin
      y_d = rnd_ff[RndW-1] ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                           : {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    end else begin
      y_d = rnd_ff[SAMPLE_WIDTH-1:0];
    end
  end

  // Multiply, accumulate and latch the intermediate word
  always_ff @(posedge clk_i) begin
    prod_q <= mul_c * mul_w;
    if (cmd_i.load) begin
      acc_fb_q <= (AccW'(sample_in_i) <<< Frac) + Half;
      acc_ff_q <= Half;
    end else begin
      if (cmd_i.fb_sub) begin
        acc_fb_q <= acc_fb_q - AccW'(prod_q);
      end
      if (cmd_i.ff_add) begin
        acc_ff_q <= acc_ff_q + AccW'(prod_q);
      end
    end
    if (cmd_i.w0_latch) begin
      w0_q     <= w0_d;
      sat_w0_q <= fb_clip;
    end
    if (cmd_i.commit) begin
      sample_out_q <= y_d;
      saturated_q  <= sat_w0_q | ff_clip;
    end
  end

  // Clear on request, advance the delay line when a result is committed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (cmd_i.load && clear_delay_i) begin
      w1_q <= '0;
      w2_q <= '0;
    end else if (cmd_i.commit) begin
      w2_q <= w1_q;
      w1_q <= w0_q;
    end
  end

  assign sample_out_o = sample_out_q;
  assign saturated_o  = saturated_q;

endmodule

>>> sv/biquad_iir_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_core
// Direct form II biquad section with Q4.20 coefficients, saturating delay words
// and a saturating output.
// ----------------------------------------------------------------------------
// One signed multiplier with a registered product is shared by all five
// coefficient products, followed by a final accumulate and the round-and-clip
// step; a request is not accepted until the one before it has been committed.
// The input ready flag is registered, so it returns in the cycle after the
// result is committed. The result sits in an output register, so the next
// request is accepted while it waits; if it is still not taken when the
// following result is ready, the core holds until it is. Both sums are formed
// exactly and rounded once, half up, to a sample LSB. The coefficient registers
// (b0, b1, b2, a1, a2 at indexes 0 to 4) are to be written only while the core
// is idle; the core itself does not enforce this. b0 resets to unity, the rest
// to zero.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core #(
  parameter int unsigned SAMPLE_WIDTH = 16,
  parameter int unsigned COEF_WIDTH   = 24,
  parameter int unsigned STATE_WIDTH  = 24
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [biq_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [COEF_WIDTH-1:0]          cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  input  logic                           clear_delay_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out_o,
  output logic                           saturated_o
);
  import biq_pkg::*;

  biq_cmd_t cmd;

  // Sequence the multiply-accumulate steps
  biq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Arithmetic, coefficients and delay line
  biq_datapath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .COEF_WIDTH   (COEF_WIDTH),
    .STATE_WIDTH  (STATE_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .sample_in_i   (sample_in_i),
    .clear_delay_i (clear_delay_i),
    .cmd_i         (cmd),
    .sample_out_o  (sample_out_o),
    .saturated_o   (saturated_o)
  );

endmodule

>>> sv/biq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biq_checker
// Port-level checks on the biquad core: result hold under stall and the
// request sequencing seen from the handshakes.
// ----------------------------------------------------------------------------
module biq_checker #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [SAMPLE_WIDTH-1:0] sample_out_o,
  input logic                    saturated_o
);

  // A stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(sample_out_o) && $stable(saturated_o))
    else $error("result changed while stalled");

  // Accepting a request makes the core busy
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  // Ready returns only together with a delivered result
  a_ready_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o)
    else $error("core freed without a result");

  // No result appears within the multiply sequence
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=>
      !out_valid_o ##1 !out_valid_o ##1 !out_valid_o ##1 !out_valid_o)
    else $error("result earlier than the multiply sequence allows");

endmodule

bind biquad_iir_filter_core biq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .sample_out_o (sample_out_o),
  .saturated_o  (saturated_o)
);

>>> tb/biquad_iir_filter_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_filter_core_test
// Self-checking bench for the direct form II biquad core. Each accepted request
// runs through a bit-exact fixed-point model of the section (exact sums,
// half-up rounding, saturating delay words and output), and every returned
// result is compared with the oldest prediction. The run covers the reset
// coefficients, the register map, rounding, the coefficient extremes, unstable
// feedback and long random traffic under several handshake stall patterns.
// ----------------------------------------------------------------------------
module biquad_iir_filter_core_test;
  import biq_pkg::*;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CoefW   = 24;
  localparam int unsigned StateW  = 24;
  localparam int unsigned CoefFrac = CoefW - 4;

  localparam logic signed [CoefW-1:0]   CoefUnity = CoefW'(1) << CoefFrac;
  localparam logic signed [CoefW-1:0]   CoefMax   = {1'b0, {(CoefW-1){1'b1}}};
  localparam logic signed [CoefW-1:0]   CoefMin   = {1'b1, {(CoefW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SampleMax = {1'b0, {(SampleW-1){1'b1}}};
  localparam logic signed [SampleW-1:0] SampleMin = {1'b1, {(SampleW-1){1'b0}}};

  localparam int SettleCycles = 16;
  localparam int CycleLimit   = 400000;
  localparam int ItemsPerSet  = 75;

  typedef struct {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coef_set_t;

  typedef struct {
    logic signed [SampleW-1:0] sample;
    logic                      sat;
  } filter_result_t;

  // DUT ports
  logic                      clk_i         = 1'b0;
  logic                      rst_ni        = 1'b0;
  logic                      cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]        cfg_addr_i    = REG_B0;
  logic [CoefW-1:0]          cfg_wdata_i   = '0;
  logic                      in_valid_i    = 1'b0;
  logic                      in_ready_o;
  logic signed [SampleW-1:0] sample_in_i   = '0;
  logic                      clear_delay_i = 1'b0;
  logic                      out_valid_o;
  logic                      out_ready_i   = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;
  logic                      saturated_o;

  // Filter mirror and bookkeeping
  coef_set_t      coefs;
  longint         delay_w1;
  longint         delay_w2;
  filter_result_t pending_q[$];
  int             idle_pct     = 0;
  int             stall_pct    = 0;
  int             fail_count   = 0;
  int             sent_count   = 0;
  int             result_count = 0;
  int             sat_count    = 0;
  int             set_count    = 0;
  int             cycle_count  = 0;

  biquad_iir_filter_core #(
    .SAMPLE_WIDTH(SampleW),
    .COEF_WIDTH  (CoefW),
    .STATE_WIDTH (StateW)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .clear_delay_i(clear_delay_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results pending", cycle_count,
               pending_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stall the result channel at random
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Compare each returned result with the oldest prediction
  always @(posedge clk_i) begin : check_results
    filter_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: sample_out=%0d saturated=%0b",
               sample_out_o, saturated_o);
        fail_count++;
      end else begin
        want = pending_q.pop_front();
        result_count++;
        if (sample_out_o !== want.sample) begin
          $error("sample_out mismatch: expected %0d, got %0d", want.sample,
                 sample_out_o);
          fail_count++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated mismatch: expected %0b, got %0b", want.sat,
                 saturated_o);
          fail_count++;
        end
      end
    end
  end

  // Round a Q.20 sum half up to a sample LSB
  function automatic longint round_half_up(input longint acc);
    return (acc + (longint'(1) <<< (CoefFrac - 1))) >>> CoefFrac;
  endfunction

  function automatic longint clip_to(input longint v, input int w, inout bit sat);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      sat = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Advance the filter mirror by one sample and queue the expected output
  function automatic void filter_step(input logic signed [SampleW-1:0] x,
                                      input logic clr);
    longint         acc;
    longint         w0;
    bit             sat;
    filter_result_t res;
    sat = 1'b0;
    if (clr) begin
      delay_w1 = 0;
      delay_w2 = 0;
    end
    acc = (longint'(x) <<< CoefFrac) - longint'(coefs.a1) * delay_w1
          - longint'(coefs.a2) * delay_w2;
    w0 = clip_to(round_half_up(acc), StateW, sat);
    acc = longint'(coefs.b0) * w0 + longint'(coefs.b1) * delay_w1
          + longint'(coefs.b2) * delay_w2;
    res.sample = SampleW'(clip_to(round_half_up(acc), SampleW, sat));
    res.sat    = sat;
    delay_w2 = delay_w1;
    delay_w1 = w0;
    if (sat) sat_count++;
    pending_q.push_back(res);
  endfunction

  function automatic void mirror_reg(input logic [CfgIdxW-1:0] idx,
                                     input logic [CoefW-1:0] val);
    case (idx)
      REG_B0: coefs.b0 = val;
      REG_B1: coefs.b1 = val;
      REG_B2: coefs.b2 = val;
      REG_A1: coefs.a1 = val;
      REG_A2: coefs.a2 = val;
      default: ;
    endcase
  endfunction

  // Send one request, idling first at random, and predict it on acceptance
  task automatic send_sample(input logic signed [SampleW-1:0] x, input logic clr);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_in_i   <= x;
    clear_delay_i <= clr;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    filter_step(x, clr);
    sent_count++;
  endtask

  // Drop valid and wait until the core has returned everything
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CoefW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    mirror_reg(idx, val);
  endtask

  task automatic program_coefs(input coef_set_t c);
    write_reg(REG_B0, c.b0);
    write_reg(REG_B1, c.b1);
    write_reg(REG_B2, c.b2);
    write_reg(REG_A1, c.a1);
    write_reg(REG_A2, c.a2);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    set_count++;
  endtask

  function automatic coef_set_t make_set(input logic signed [CoefW-1:0] b0,
                                         input logic signed [CoefW-1:0] b1,
                                         input logic signed [CoefW-1:0] b2,
                                         input logic signed [CoefW-1:0] a1,
                                         input logic signed [CoefW-1:0] a2);
    coef_set_t c;
    c.b0 = b0;
    c.b1 = b1;
    c.b2 = b2;
    c.a1 = a1;
    c.a2 = a2;
    return c;
  endfunction

  function automatic logic signed [CoefW-1:0] edge_coef();
    case ($urandom_range(4))
      0: return CoefMax;
      1: return CoefMin;
      2: return '0;
      3: return CoefUnity;
      default: return CoefW'($urandom);
    endcase
  endfunction

  function automatic logic signed [CoefW-1:0] span_coef(input int lim);
    return CoefW'(int'($urandom_range(2 * lim)) - lim);
  endfunction

  // Full-range noise, a mostly stable section, or a mix of edge values
  function automatic coef_set_t random_coefs(input int kind);
    coef_set_t c;
    int        lim;
    case (kind)
      0: c = make_set(CoefW'($urandom), CoefW'($urandom), CoefW'($urandom),
                      CoefW'($urandom), CoefW'($urandom));
      1: begin
        c.a2 = span_coef(943718);
        lim  = (int'(CoefUnity) + int'(c.a2)) * 95 / 100;
        c.a1 = span_coef(lim);
        c.b0 = span_coef(2 * int'(CoefUnity));
        c.b1 = span_coef(2 * int'(CoefUnity));
        c.b2 = span_coef(2 * int'(CoefUnity));
      end
      default: c = make_set(edge_coef(), edge_coef(), edge_coef(), edge_coef(),
                            edge_coef());
    endcase
    return c;
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return SampleW'($urandom);
    if (pick < 90) return SampleW'(int'($urandom_range(512)) - 256);
    return pick[0] ? SampleMax : SampleMin;
  endfunction

  // Reset coefficients give unity gain
  task automatic test_unity_gain();
    idle_pct  = 0;
    stall_pct = 0;
    send_sample(SampleMax, 1'b0);
    send_sample(SampleMin, 1'b0);
    send_sample('0, 1'b1);
    send_sample(16'sd1, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sh5555, 1'b1);
  endtask

  // Writes to unused indexes must leave the coefficients alone
  task automatic test_register_map();
    wait_idle();
    for (int i = int'(REG_A2) + 1; i < (1 << CfgIdxW); i++) begin
      write_reg(CfgIdxW'(i), CoefMax);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    send_sample(16'sd1234, 1'b1);
    send_sample(-16'sd4321, 1'b0);
  endtask

  // Half-way sums round up
  task automatic test_rounding();
    wait_idle();
    program_coefs(make_set(CoefUnity >>> 1, '0, '0, '0, '0));
    send_sample(16'sd1, 1'b1);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd3, 1'b0);
    send_sample(-16'sd3, 1'b0);
  endtask

  task automatic test_coef_extremes();
    wait_idle();
    program_coefs(make_set(CoefMax, CoefMax, CoefMax, CoefMax, CoefMax));
    send_sample(SampleMax, 1'b1);
    send_sample(SampleMin, 1'b0);
    send_sample(SampleMax, 1'b0);
    wait_idle();
    program_coefs(make_set(CoefMin, CoefMin, CoefMin, CoefMin, CoefMin));
    send_sample(SampleMin, 1'b1);
    send_sample(SampleMax, 1'b0);
  endtask

  // Strong positive feedback drives the delay words into their clip limits
  task automatic test_unstable_feedback();
    wait_idle();
    program_coefs(make_set(CoefUnity >>> 4, '0, '0, CoefMin, '0));
    idle_pct  = 33;
    stall_pct = 33;
    repeat (5) send_sample(SampleMax, 1'b0);
    send_sample(16'sd100, 1'b1);
  endtask

  task automatic test_random_traffic();
    int idle_mode[4]  = '{0, 66, 0, 33};
    int stall_mode[4] = '{0, 0, 66, 33};
    for (int m = 0; m < 4; m++) begin
      for (int kind = 0; kind < 3; kind++) begin
        wait_idle();
        program_coefs(random_coefs(kind));
        idle_pct  = idle_mode[m];
        stall_pct = stall_mode[m];
        repeat (ItemsPerSet) send_sample(random_sample(), $urandom_range(19) == 0);
      end
    end
  endtask

  initial begin
    coefs    = make_set(CoefUnity, '0, '0, '0, '0);
    delay_w1 = 0;
    delay_w2 = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_unity_gain();
    test_register_map();
    test_rounding();
    test_coef_extremes();
    test_unstable_feedback();
    test_random_traffic();
    wait_idle();

    $display("Sent %0d samples through %0d coefficient sets; checked %0d results.",
             sent_count, set_count, result_count);
    $display("%0d results clipped; sender and receiver stalls of 0, 33 and 66 percent.",
             sat_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
